// File: src/tfl_pkg.sv
// Shared widths, types and codes for the thermistor filter and linearizer.
package tfl_pkg;

	// Data widths fixed by the interface
	localparam int ADC_W        = 12;
	localparam int PT_ADC_W     = 13;
	localparam int TEMP_W       = 18;
	localparam int ENTRY_IDX_W  = 5;
	localparam int GAIN_W       = 16;
	localparam int LIMIT_W      = 16;
	localparam int POINTS_W     = 5;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;

	// Table and level format
	localparam int TABLE_POINTS        = 24;
	localparam int LEVEL_FRACTION_BITS = 16;
	localparam int ADDR_W              = $clog2(TABLE_POINTS);
	localparam int LEVEL_W             = ADC_W + LEVEL_FRACTION_BITS;
	localparam int PT_X_W              = PT_ADC_W + LEVEL_FRACTION_BITS;

	// Low-pass datapath
	localparam int FPROD_W = LEVEL_W + 1 + GAIN_W + 1;
	localparam int DELTA_W = FPROD_W - GAIN_W;
	localparam int FSUM_W  = DELTA_W + 1;

	// Interpolation datapath
	localparam int PA_W   = TEMP_W + PT_ADC_W + 1;
	localparam int NUM_W  = TEMP_W + 1 + LEVEL_W + 1;
	localparam int DVD_W  = NUM_W - 1 - LEVEL_FRACTION_BITS;
	localparam int DCNT_W = $clog2(DVD_W + 1);

	// Register reset values
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(6554);
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(2000);
	localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(24);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE    = 2'd2;

	// Input word modes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TABLE  = 1'b1;

	typedef struct packed {
		logic [PT_ADC_W-1:0]      adc;
		logic signed [TEMP_W-1:0] temp;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: src/thermistor_filter_linearizer.sv
// Sequence: a table word is written on acceptance; a sample word updates the level
// in S_FILT; an emitting sample reads the n points in use, then divides unless the
// result needs no division. One word at a time; the 31-step divider and one RAM
// read per table point set the emitting-sample time, the output register lets the
// next word enter. Reset: gain 6554, limit 2000, points 24, level and tick count
// zero; the table RAM is not cleared and holds whatever it held until written.
module thermistor_filter_linearizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [tfl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tfl_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input words
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [tfl_pkg::ADC_W-1:0]             adc_sample,
	input  logic [tfl_pkg::ENTRY_IDX_W-1:0]       entry_index,
	input  logic [tfl_pkg::PT_ADC_W-1:0]          entry_adc,
	input  logic signed [tfl_pkg::TEMP_W-1:0]     entry_temp,
	// result words
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [tfl_pkg::TEMP_W-1:0]     temperature,
	output logic [tfl_pkg::ADC_W-1:0]             filtered_adc
);

	localparam int FB  = tfl_pkg::LEVEL_FRACTION_BITS;
	localparam int LW  = tfl_pkg::LEVEL_W;
	localparam int XW  = tfl_pkg::PT_X_W;
	localparam int AW  = tfl_pkg::ADDR_W;
	localparam int TW  = tfl_pkg::TEMP_W;
	localparam int PAW = tfl_pkg::PT_ADC_W;
	localparam int NW  = tfl_pkg::NUM_W;

	// Sequencer. One-hot codes.
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,  // waiting for a word
		S_FILT  = 10'b00_0000_0010,  // filter add/saturate, tick count
		S_READ  = 10'b00_0000_0100,  // issue table reads 0..n-1
		S_DRAIN = 10'b00_0000_1000,  // last read data returns
		S_SETUP = 10'b00_0001_0000,  // pick segment and operands
		S_MUL   = 10'b00_0010_0000,  // two products
		S_SUM   = 10'b00_0100_0000,  // numerator
		S_DIVST = 10'b00_1000_0000,  // magnitude, launch divider
		S_DIV   = 10'b01_0000_0000,  // wait for quotient
		S_OUT   = 10'b10_0000_0000   // load output register
	} state_t;

	state_t state_q;

	// configuration registers
	logic [tfl_pkg::GAIN_W-1:0]   gain_q;
	logic [tfl_pkg::LIMIT_W-1:0]  limit_q;
	logic [tfl_pkg::POINTS_W-1:0] points_q;
	logic [AW-1:0]                last_idx;

	logic                         accept;
	logic                         tab_we;
	logic                         sample_load;
	logic [LW-1:0]                level;
	logic [tfl_pkg::LIMIT_W-1:0]  tick_q;

	// table RAM
	logic [AW-1:0]                addr_q;
	tfl_pkg::entry_t              wr_entry;
	tfl_pkg::entry_t              rd_data;
	logic                         rd_valid_s1;
	logic                         rd_first_s1;

	// search results
	logic [PAW-1:0]               adc0_q;
	logic signed [TW-1:0]         temp0_q;
	logic [PAW-1:0]               prev_adc_q;
	logic signed [TW-1:0]         prev_temp_q;
	logic [PAW-1:0]               seg_lo_adc_q;
	logic signed [TW-1:0]         seg_lo_temp_q;
	logic [PAW-1:0]               seg_hi_adc_q;
	logic signed [TW-1:0]         seg_hi_temp_q;
	logic                         seg_hit_q;

	logic [XW-1:0]                x_ext;
	logic [XW-1:0]                cur_pt;
	logic [XW-1:0]                prev_pt;
	logic [XW-1:0]                first_pt;
	logic [XW-1:0]                seg_lo_pt;

	// interpolation operands
	logic signed [TW-1:0]         ylo_q;
	logic signed [TW:0]           dy_q;
	logic [LW-1:0]                dx_q;
	logic [PAW-1:0]               da_q;
	logic                         direct_q;
	logic [TW-1:0]                direct_val_q;
	logic signed [tfl_pkg::PA_W-1:0] pa_q;
	logic signed [NW-1:0]         pb_q;
	logic signed [NW-1:0]         num_q;
	logic                         neg_q;
	logic [NW-1:0]                mag;
	logic [TW-1:0]                quo_t;

	logic                         div_start;
	tfl_pkg::div_status_t         div_status;
	logic [tfl_pkg::DVD_W-1:0]    div_quotient;

	logic [TW-1:0]                result_q;
	logic                         out_valid_q;
	logic [TW-1:0]                temp_out_q;
	logic [tfl_pkg::ADC_W-1:0]    adc_out_q;
	logic                         out_free;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= tfl_pkg::GAIN_RESET;
			limit_q  <= tfl_pkg::LIMIT_RESET;
			points_q <= tfl_pkg::POINTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfl_pkg::CFG_FILTER_GAIN: begin
					gain_q <= cfg_data[tfl_pkg::GAIN_W-1:0];
				end
				tfl_pkg::CFG_DECIMATION_LIMIT: begin
					limit_q <= cfg_data[tfl_pkg::LIMIT_W-1:0];
				end
				tfl_pkg::CFG_POINTS_IN_USE: begin
					points_q <= cfg_data[tfl_pkg::POINTS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// points in use clamped to [2, TABLE_POINTS]; index of the last one
	always_comb begin
		if (int'(points_q) < 2) begin
			last_idx = AW'(1);
		end else if (int'(points_q) > tfl_pkg::TABLE_POINTS) begin
			last_idx = AW'(tfl_pkg::TABLE_POINTS - 1);
		end else begin
			last_idx = AW'(points_q - 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Input side: one word at a time, taken only in S_IDLE
	// ------------------------------------------------------------------
	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign sample_load = accept && (mode == tfl_pkg::MODE_SAMPLE);
	// writes past the table end are dropped
	assign tab_we      = accept && (mode == tfl_pkg::MODE_TABLE)
	                     && (int'(entry_index) < tfl_pkg::TABLE_POINTS);

	assign wr_entry.adc  = entry_adc;
	assign wr_entry.temp = entry_temp;

	tfl_table_ram u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (entry_index[AW-1:0]),
		.wdata (wr_entry),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Level update: product registered on accept, level written in S_FILT.
	tfl_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (sample_load),
		.sample (adc_sample),
		.gain   (gain_q),
		.level  (level)
	);

	// ------------------------------------------------------------------
	// Segment search. Read data for entry k arrives in the cycle after its
	// address; each pair (k-1, k) that brackets the level overwrites the
	// stored segment, so the last bracketing segment in table order wins.
	// After the sweep prev_* holds the last point in use.
	// ------------------------------------------------------------------
	assign x_ext     = XW'(level);
	assign cur_pt    = {rd_data.adc, {FB{1'b0}}};
	assign prev_pt   = {prev_adc_q, {FB{1'b0}}};
	assign first_pt  = {adc0_q, {FB{1'b0}}};
	assign seg_lo_pt = {seg_lo_adc_q, {FB{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			seg_hit_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_READ);
			if (state_q == S_FILT) begin
				seg_hit_q <= 1'b0;
			end else if (rd_valid_s1 && !rd_first_s1 && x_ext > prev_pt
			             && x_ext <= cur_pt) begin
				seg_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_first_s1 <= (addr_q == '0);
		if (rd_valid_s1) begin
			prev_adc_q  <= rd_data.adc;
			prev_temp_q <= rd_data.temp;
			if (rd_first_s1) begin
				adc0_q  <= rd_data.adc;
				temp0_q <= rd_data.temp;
			end else if (x_ext > prev_pt && x_ext <= cur_pt) begin
				seg_lo_adc_q  <= prev_adc_q;
				seg_lo_temp_q <= prev_temp_q;
				seg_hi_adc_q  <= rd_data.adc;
				seg_hi_temp_q <= rd_data.temp;
			end
		end
	end

	// ------------------------------------------------------------------
	// Interpolation: (ylo*span + dy*dx) / span, truncated toward zero.
	// span = da << FB, so |num| >> FB divided by da gives the same quotient.
	// ------------------------------------------------------------------
	assign mag       = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
	assign div_start = (state_q == S_DIVST);
	assign quo_t     = div_quotient[TW-1:0];

	tfl_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag[NW-2:FB]),
		.divisor  (da_q),
		.status   (div_status),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SETUP: begin
				priority if (x_ext <= first_pt) begin
					// between the origin and the first point; a first point at
					// zero ADC gives the origin's temperature
					ylo_q        <= '0;
					dy_q         <= (TW+1)'(temp0_q);
					dx_q         <= level;
					da_q         <= adc0_q;
					direct_q     <= (adc0_q == '0);
					direct_val_q <= '0;
				end else if (x_ext > prev_pt) begin
					// above the last point: clamp
					direct_q     <= 1'b1;
					direct_val_q <= prev_temp_q;
				end else if (seg_hit_q) begin
					ylo_q    <= seg_lo_temp_q;
					dy_q     <= (TW+1)'(seg_hi_temp_q) - (TW+1)'(seg_lo_temp_q);
					dx_q     <= LW'(x_ext - seg_lo_pt);
					da_q     <= seg_hi_adc_q - seg_lo_adc_q;
					direct_q <= 1'b0;
				end else begin
					// table not monotonic, nothing brackets the level
					direct_q     <= 1'b1;
					direct_val_q <= '0;
				end
			end
			S_MUL: begin
				pa_q <= ylo_q * $signed({1'b0, da_q});
				pb_q <= dy_q * $signed({1'b0, dx_q});
			end
			S_SUM: begin
				num_q <= (NW'(pa_q) <<< FB) + pb_q;
			end
			S_DIVST: begin
				neg_q <= num_q[NW-1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL && direct_q) begin
			result_q <= direct_val_q;
		end else if (state_q == S_DIV && div_status.done) begin
			result_q <= neg_q ? (~quo_t + 1'b1) : quo_t;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer, tick counter and table read address
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q  <= '0;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_load) begin
						state_q <= S_FILT;
					end
				end
				S_FILT: begin
					// count compared before its increment; 16-bit wrap
					if (tick_q > limit_q) begin
						tick_q  <= '0;
						addr_q  <= '0;
						state_q <= S_READ;
					end else begin
						tick_q  <= tick_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (addr_q == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= direct_q ? S_OUT : S_SUM;
				end
				S_SUM: begin
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_status.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds one finished word while input continues
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			temp_out_q <= result_q;
			adc_out_q  <= level[LW-1:FB];
		end
	end

	assign out_valid    = out_valid_q;
	assign temperature  = $signed(temp_out_q);
	assign filtered_adc = adc_out_q;

endmodule

// File: src/tfl_table_ram.sv
// Calibration table RAM: one write port, one read port, registered read data.
module tfl_table_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [tfl_pkg::ADDR_W-1:0] waddr,
	input  tfl_pkg::entry_t            wdata,
	input  logic [tfl_pkg::ADDR_W-1:0] raddr,
	output tfl_pkg::entry_t            rdata
);

	tfl_pkg::entry_t mem [tfl_pkg::TABLE_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: src/tfl_filter.sv
// First-order low-pass level: multiply stage, then add and saturate.
module tfl_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [tfl_pkg::ADC_W-1:0]   sample,
	input  logic [tfl_pkg::GAIN_W-1:0]  gain,
	output logic [tfl_pkg::LEVEL_W-1:0] level
);

	localparam int LW = tfl_pkg::LEVEL_W;
	localparam int FB = tfl_pkg::LEVEL_FRACTION_BITS;
	localparam int PW = tfl_pkg::FPROD_W;
	localparam int GW = tfl_pkg::GAIN_W;
	localparam int SW = tfl_pkg::FSUM_W;

	logic [LW-1:0]             level_q;
	logic signed [LW:0]        diff;
	logic signed [PW-1:0]      prod_s1;
	logic                      step_s1;
	logic signed [PW-1:0]      biased;
	logic signed [PW-GW-1:0]   delta;
	logic signed [SW-1:0]      sum;
	logic [LW-1:0]             level_next;

	assign diff = $signed({1'b0, sample, {FB{1'b0}}}) - $signed({1'b0, level_q});

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= diff * $signed({1'b0, gain});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= load;
		end
	end

	// divide by 2^GAIN_W, truncating toward zero
	always_comb begin
		biased = prod_s1 + $signed({{(PW-GW){1'b0}}, {GW{prod_s1[PW-1]}}});
		delta  = biased[PW-1:GW];
		sum    = SW'(delta) + $signed({{(SW-LW){1'b0}}, level_q});
		if (sum[SW-1]) begin
			level_next = '0;
		end else if (sum > $signed({{(SW-LW){1'b0}}, {LW{1'b1}}})) begin
			level_next = {LW{1'b1}};
		end else begin
			level_next = sum[LW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (step_s1) begin
			level_q <= level_next;
		end
	end

	assign level = level_q;

endmodule

// File: src/tfl_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module tfl_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tfl_pkg::DVD_W-1:0]    dividend,
	input  logic [tfl_pkg::PT_ADC_W-1:0] divisor,
	output tfl_pkg::div_status_t         status,
	output logic [tfl_pkg::DVD_W-1:0]    quotient
);

	localparam int QW = tfl_pkg::DVD_W;
	localparam int DW = tfl_pkg::PT_ADC_W;
	localparam int CW = tfl_pkg::DCNT_W;

	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic [QW-1:0]  quo_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  dvs_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic           fits;

	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// File: tb/tb_thermistor_filter_linearizer.sv
// Self-checking testbench for the thermistor filter and linearizer.
module tb_thermistor_filter_linearizer;
	timeunit 1ns;
	timeprecision 1ps;

	import tfl_pkg::*;

	// settle time after the last reading, above the worst emitting latency
	localparam int QUIET_CYCLES  = 100;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 30;
	localparam int HOLD_CYCLES   = 400;
	localparam int WATCHDOG_NS   = 2_000_000;
	localparam int IDX_TOP       = (1 << ENTRY_IDX_W) - 1;
	localparam int PT_ADC_TOP    = (1 << PT_ADC_W) - 1;
	localparam int ADC_TOP       = (1 << ADC_W) - 1;

	// shapes of calibration table loaded into the block
	typedef enum int {SHAPE_FALLING, SHAPE_RISING, SHAPE_SCRAMBLED} table_shape_t;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [ADC_W-1:0]         adc;
	} reading_t;

	// Tracks the filter, tick counter and calibration table, and holds the
	// readings still owed by the block.
	class reading_scoreboard;
		logic [GAIN_W-1:0]        gain;
		logic [LIMIT_W-1:0]       limit;
		logic [POINTS_W-1:0]      points;
		logic [LEVEL_W-1:0]       level;
		logic [LIMIT_W-1:0]       ticks;
		logic [PT_ADC_W-1:0]      pt_adc[TABLE_POINTS];
		logic signed [TEMP_W-1:0] pt_temp[TABLE_POINTS];
		reading_t                 expected_readings[$];
		int                       failures;
		int                       checked;
		int                       samples;
		int                       entries;

		function new();
			gain     = GAIN_RESET;
			limit    = LIMIT_RESET;
			points   = POINTS_RESET;
			level    = '0;
			ticks    = '0;
			failures = 0;
			checked  = 0;
			samples  = 0;
			entries  = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_FILTER_GAIN:      gain = val;
				CFG_DECIMATION_LIMIT: limit = val;
				CFG_POINTS_IN_USE:    points = val[POINTS_W-1:0];
				default: ;
			endcase
		endfunction

		// straight line between two breakpoints; a span that is not positive gives ylo
		function longint segment_temp(longint xlo, longint xhi, longint ylo, longint yhi,
				longint x);
			longint span;
			span = xhi - xlo;
			if (span <= 0)
				return ylo;
			return (ylo * span + (yhi - ylo) * (x - xlo)) / span;
		endfunction

		function longint table_temp(longint x);
			int     n;
			longint xlo;
			longint xhi;
			longint result;
			n = int'(points);
			if (n < 2)
				n = 2;
			if (n > TABLE_POINTS)
				n = TABLE_POINTS;
			xlo = longint'(pt_adc[0]) <<< LEVEL_FRACTION_BITS;
			// at or below the first breakpoint: line from the origin
			if (x <= xlo)
				return segment_temp(0, xlo, 0, longint'(pt_temp[0]), x);
			// past the last breakpoint in use: clamp
			if (x > (longint'(pt_adc[n-1]) <<< LEVEL_FRACTION_BITS))
				return longint'(pt_temp[n-1]);
			// later matching segments override earlier ones; no match leaves zero
			result = 0;
			for (int i = 0; i + 1 < n; i++) begin
				xlo = longint'(pt_adc[i]) <<< LEVEL_FRACTION_BITS;
				xhi = longint'(pt_adc[i+1]) <<< LEVEL_FRACTION_BITS;
				if (x <= xhi && x > xlo)
					result = segment_temp(xlo, xhi, longint'(pt_temp[i]),
						longint'(pt_temp[i+1]), x);
			end
			return result;
		endfunction

		function void note_word(logic m, logic [ADC_W-1:0] sample,
				logic [ENTRY_IDX_W-1:0] idx, logic [PT_ADC_W-1:0] eadc,
				logic signed [TEMP_W-1:0] etemp);
			longint   step;
			longint   next_level;
			bit       fire;
			reading_t r;
			if (m == MODE_TABLE) begin
				entries++;
				if (idx < TABLE_POINTS) begin
					pt_adc[idx]  = eadc;
					pt_temp[idx] = etemp;
				end
				return;
			end
			samples++;
			// low-pass step, truncated toward zero, then saturated to the level range
			step = ((longint'(sample) <<< LEVEL_FRACTION_BITS) - longint'(level)) * longint'(gain);
			next_level = longint'(level) + step / (longint'(1) <<< GAIN_W);
			if (next_level < 0)
				next_level = 0;
			if (next_level > (longint'(1) <<< LEVEL_W) - 1)
				next_level = (longint'(1) <<< LEVEL_W) - 1;
			level = next_level[LEVEL_W-1:0];
			fire  = ticks > limit;
			ticks = ticks + 1'b1;
			if (!fire)
				return;
			ticks  = '0;
			r.temp = TEMP_W'(table_temp(longint'(level)));
			r.adc  = level[LEVEL_W-1:LEVEL_FRACTION_BITS];
			expected_readings.push_back(r);
		endfunction

		function void check_word(logic signed [TEMP_W-1:0] temp, logic [ADC_W-1:0] adc);
			reading_t r;
			if (expected_readings.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected reading: temperature %0d filtered_adc %0d", temp, adc);
				return;
			end
			r = expected_readings.pop_front();
			checked++;
			if (temp !== r.temp || adc !== r.adc) begin
				failures++;
				if (failures <= 10)
					$display("reading %0d: temperature %0d (exp %0d) filtered_adc %0d (exp %0d)",
						checked, temp, r.temp, adc, r.adc);
			end
		endfunction
	endclass

	// DUT signals; every input starts at a known value
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       mode = MODE_SAMPLE;
	logic [ADC_W-1:0]           adc_sample = '0;
	logic [ENTRY_IDX_W-1:0]     entry_index = '0;
	logic [PT_ADC_W-1:0]        entry_adc = '0;
	logic signed [TEMP_W-1:0]   entry_temp = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [TEMP_W-1:0]   temperature;
	logic [ADC_W-1:0]           filtered_adc;

	// traffic shaping, in percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// long output hold: requested by the stimulus, counted down by the receiver
	int hold_req      = 0;
	int hold_left     = 0;
	int settings_used = 0;

	reading_scoreboard sb = new();

	thermistor_filter_linearizer uut (.*);

	always #1 clk = ~clk;

	// receiver: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// result monitor: handshake values are the ones seen before this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(temperature, filtered_adc);
	end

	// Offers one word after an optional idle gap and returns at the edge that
	// accepts it. Valid stays high on return so back-to-back words stay back to back.
	task automatic send_word(input logic m, input logic [ADC_W-1:0] s,
			input logic [ENTRY_IDX_W-1:0] idx, input logic [PT_ADC_W-1:0] a,
			input logic signed [TEMP_W-1:0] t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		adc_sample  <= s;
		entry_index <= idx;
		entry_adc   <= a;
		entry_temp  <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(m, s, idx, a, t);
	endtask

	// sample word; the table fields carry noise the block must ignore
	task automatic send_sample(input int s);
		send_word(MODE_SAMPLE, ADC_W'(s), ENTRY_IDX_W'($urandom_range(0, IDX_TOP)),
			PT_ADC_W'($urandom_range(0, PT_ADC_TOP)), TEMP_W'($urandom));
	endtask

	task automatic send_entry(input int idx, input int a, input int t);
		send_word(MODE_TABLE, ADC_W'($urandom), ENTRY_IDX_W'(idx), PT_ADC_W'(a), TEMP_W'(t));
	endtask

	// drop valid, let every owed reading arrive, then let the block settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.expected_readings.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic apply_settings(input int gain, input int limit, input int points);
		wait_quiet();
		write_register(CFG_FILTER_GAIN, CFG_DATA_W'(gain));
		write_register(CFG_DECIMATION_LIMIT, CFG_DATA_W'(limit));
		write_register(CFG_POINTS_IN_USE, CFG_DATA_W'(points));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Writes all table entries in order, then one write past the end that the
	// block drops. Falling/rising shapes are monotonic in adc (equal neighbors
	// allowed); the scrambled shape is arbitrary and full range.
	task automatic load_table(input table_shape_t shape, input int first_adc);
		int a;
		int t;
		a = first_adc;
		t = (shape == SHAPE_FALLING) ? 15000 : -4000;
		for (int i = 0; i < TABLE_POINTS; i++) begin
			if (shape == SHAPE_SCRAMBLED) begin
				send_entry(i, $urandom_range(0, PT_ADC_TOP), $urandom);
			end else begin
				send_entry(i, a, t);
				a += $urandom_range(0, 300);
				if (shape == SHAPE_FALLING)
					t -= $urandom_range(0, 1500);
				else
					t += $urandom_range(0, 1500);
			end
		end
		send_entry($urandom_range(TABLE_POINTS, IDX_TOP), $urandom_range(0, PT_ADC_TOP),
			$urandom);
	endtask

	// watchdog
	initial begin
		#(WATCHDOG_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gain;
		int limit;
		int points;
		int r;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed part ----------------
		// Whole table written before any sample, first breakpoint at zero adc.
		load_table(SHAPE_FALLING, 0);
		// Reset settings: limit 2000, so these must not emit; level stays zero.
		repeat (3) send_sample(0);
		// Only the limit changes, so gain and points keep their reset values.
		wait_quiet();
		write_register(CFG_DECIMATION_LIMIT, CFG_DATA_W'(0));
		cfg_we <= 1'b0;
		// Level zero on a zero-width first span: reads as the origin's temp.
		send_sample(0);
		// Two full-scale samples through the reset gain, the second one emits.
		repeat (2) send_sample(ADC_TOP);

		// Full gain: level jumps to near full scale, most likely above the last breakpoint.
		apply_settings((1 << GAIN_W) - 1, 0, TABLE_POINTS);
		repeat (2) send_sample(ADC_TOP);
		// Fresh table with a nonzero first breakpoint, then drive the level
		// down and just below it to hit the origin line.
		load_table(SHAPE_FALLING, $urandom_range(100, 300));
		repeat (2) send_sample(0);
		repeat (2) send_sample(50);

		// Points-in-use below two and above the table size.
		apply_settings(40000, 1, 0);
		send_sample(2000);
		send_sample(3000);
		send_sample(ADC_TOP);
		apply_settings(40000, 1, (1 << POINTS_W) - 1);
		repeat (3) send_sample($urandom_range(0, ADC_TOP));

		// Zero gain freezes the level; the top limit never lets the count pass.
		apply_settings(0, (1 << LIMIT_W) - 1, 1);
		repeat (4) send_sample($urandom_range(0, ADC_TOP));
		// Smallest gain and two points; the count left over emits at once.
		apply_settings(1, 0, 2);
		repeat (2) send_sample(ADC_TOP);

		// ---------------- random part ----------------
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 55;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 55;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct     = 36;
				end
			endcase
			gain  = (p % 2) ? $urandom_range(20000, (1 << GAIN_W) - 1)
				: $urandom_range(0, (1 << GAIN_W) - 1);
			limit = (p == 0) ? 0 : $urandom_range(0, 6);
			if (p == 3)
				points = $urandom_range(0, 1);
			else if (p == 5)
				points = $urandom_range(TABLE_POINTS + 1, (1 << POINTS_W) - 1);
			else
				points = $urandom_range(2, TABLE_POINTS);
			apply_settings(gain, limit, points);

			// First phase: the receiver holds off long enough for the block to
			// back up into its input while words keep coming.
			if (p == 0)
				hold_req = HOLD_CYCLES;

			load_table(table_shape_t'(p % 3), $urandom_range(0, 300));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				// one mid-stream pause until the block has drained
				if (p == 2 && k == PHASE_WORDS / 2)
					wait_quiet();
				r = $urandom_range(0, 99);
				if (r < 5)
					send_entry($urandom_range(0, IDX_TOP), $urandom_range(0, PT_ADC_TOP),
						$urandom);
				else if (r < 18)
					send_sample(0);
				else if (r < 30)
					send_sample(ADC_TOP);
				else
					send_sample($urandom_range(0, ADC_TOP));
			end
		end

		wait_quiet();

		$display("Checked %0d readings from %0d sample words and %0d table words.",
			sb.checked, sb.samples, sb.entries);
		$display("Covered %0d register settings, idle/stall mixes, a long output hold, %0d failures.",
			settings_used + 1, sb.failures);
		if (sb.failures == 0 && sb.expected_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: thermistor_filter_linearizer.f
src/tfl_pkg.sv
src/tfl_table_ram.sv
src/tfl_filter.sv
src/tfl_divider.sv
src/thermistor_filter_linearizer.sv
tb/tb_thermistor_filter_linearizer.sv
